// ===== design/wrg_pkg.sv =====
// shared constants, types and helpers for the water ripple grid block
// no dependencies
`default_nettype none

package wrg_pkg;

    localparam int GRID_SIZE  = 64;
    localparam int GRID_W     = $clog2(GRID_SIZE);
    localparam int CELL_COUNT = GRID_SIZE * GRID_SIZE;
    localparam int ADDR_W     = $clog2(CELL_COUNT);

    localparam int COORD_W    = 6;
    localparam int HEIGHT_W   = 16;
    localparam int DAMP_W     = 8;
    localparam int DZ_W       = 15;
    localparam int CFG_W      = 15;
    localparam int CFG_IDX_W  = 2;
    localparam int REQ_W      = 2;

    localparam logic [CFG_IDX_W-1:0] REG_DAMPING   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEAD_ZONE = 2'd1;

    localparam logic [REQ_W-1:0] REQ_STEP    = 2'd0;
    localparam logic [REQ_W-1:0] REQ_PERTURB = 2'd1;
    localparam logic [REQ_W-1:0] REQ_READ    = 2'd2;
    localparam logic [REQ_W-1:0] REQ_CLEAR   = 2'd3;

    localparam logic [DAMP_W-1:0] DAMPING_RESET   = 8'd218;
    localparam logic [DZ_W-1:0]   DEAD_ZONE_RESET = 15'd10;

    localparam logic [HEIGHT_W-1:0] HEIGHT_POS_MAX = 16'h7FFF;
    localparam logic [HEIGHT_W-1:0] HEIGHT_NEG_MAX = 16'h8000;

    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [HEIGHT_W-1:0] height_t;

    typedef struct packed {
        logic  load_row;
        logic  load_vert;
        addr_t addr;
    } upd_ctrl_t;

    typedef struct packed {
        logic    valid;
        addr_t   addr;
        height_t data;
    } grid_wr_t;

    function automatic addr_t cell_addr(input addr_t row, input addr_t col);
        addr_t full;
        full = row * ADDR_W'(GRID_SIZE) + col;
        return full;
    endfunction

endpackage

`default_nettype wire

// ===== design/wrg_ram.sv =====
// generic synchronous ram, one write port and two registered read ports
// no dependencies
`default_nettype none

module wrg_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr0,
    input  wire logic [$clog2(DEPTH)-1:0] raddr1,
    output logic      [WIDTH-1:0]         rdata0,
    output logic      [WIDTH-1:0]         rdata1
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata0_reg;
    logic [WIDTH-1:0] rdata1_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata0_reg <= mem[raddr0];
        rdata1_reg <= mem[raddr1];
    end

    assign rdata0 = rdata0_reg;
    assign rdata1 = rdata1_reg;

endmodule

`default_nettype wire

// ===== design/wrg_update.sv =====
// per-cell height update: neighbor window, damping product, rounding,
// saturation and dead zone; depends on wrg_pkg
`default_nettype none

module wrg_update (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire wrg_pkg::upd_ctrl_t          ctrl,
    input  wire wrg_pkg::height_t            newest_rd0,
    input  wire wrg_pkg::height_t            newest_rd1,
    input  wire wrg_pkg::height_t            older_rd,
    input  wire logic [wrg_pkg::DAMP_W-1:0]  damping,
    input  wire logic [wrg_pkg::DZ_W-1:0]    dead_zone,
    output wrg_pkg::grid_wr_t                wr
);

    localparam int HW      = wrg_pkg::HEIGHT_W;
    localparam int D_W     = HW + 3;
    localparam int P_W     = D_W + wrg_pkg::DAMP_W + 1;
    localparam int SHIFT   = 9;
    localparam int Q_W     = P_W - SHIFT;

    wrg_pkg::height_t left_reg, center_reg, up_reg, down_reg, old_reg;
    wrg_pkg::addr_t   hold_addr_reg, wr_addr_reg;
    logic             calc_reg, wr_valid_reg;
    logic signed [P_W-1:0] p_reg;

    logic signed [D_W-1:0] d_sum;
    logic signed [P_W-1:0] p_next;
    logic                  neg;
    logic [P_W-1:0]        mag;
    logic [P_W-1:0]        q_full;
    logic [Q_W-1:0]        q;
    wrg_pkg::height_t      lim, qs, h;
    logic                  kill;

    function automatic logic signed [D_W-1:0] sx(input wrg_pkg::height_t v);
        return $signed({{(D_W-HW){v[HW-1]}}, v});
    endfunction

    always_comb
    begin
        d_sum  = sx(up_reg) + sx(down_reg) + sx(left_reg) + sx(newest_rd0)
               - (sx(old_reg) <<< 1);
        p_next = P_W'(d_sum) * $signed({{(P_W-wrg_pkg::DAMP_W){1'b0}}, damping});
    end

    always_comb
    begin
        neg    = p_reg[P_W-1];
        mag    = neg ? P_W'(-p_reg) : P_W'(p_reg);
        q_full = mag + P_W'(256);
        q      = q_full[P_W-1:SHIFT];
        lim    = neg ? wrg_pkg::HEIGHT_NEG_MAX : wrg_pkg::HEIGHT_POS_MAX;
        qs     = (q > Q_W'(lim)) ? lim : q[HW-1:0];
        kill   = qs < {1'b0, dead_zone};
        h      = kill ? '0 : (neg ? HW'(-qs) : qs);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            calc_reg     <= 1'b0;
            wr_valid_reg <= 1'b0;
        end
        else
        begin
            calc_reg     <= ctrl.load_vert;
            wr_valid_reg <= calc_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load_row)
        begin
            left_reg   <= newest_rd0;
            center_reg <= newest_rd1;
        end
        else if (calc_reg)
        begin
            left_reg   <= center_reg;
            center_reg <= newest_rd0;
        end
        if (ctrl.load_vert)
        begin
            up_reg        <= newest_rd0;
            down_reg      <= newest_rd1;
            old_reg       <= older_rd;
            hold_addr_reg <= ctrl.addr;
        end
        if (calc_reg)
        begin
            p_reg       <= p_next;
            wr_addr_reg <= hold_addr_reg;
        end
    end

    assign wr.valid = wr_valid_reg;
    assign wr.addr  = wr_addr_reg;
    assign wr.data  = h;

endmodule

`default_nettype wire

// ===== design/water_ripple_grid_sim.sv =====
// top level of the water ripple grid: request sequencer, config registers,
// two height grid rams; depends on wrg_pkg, wrg_ram, wrg_update
`default_nettype none

// usage
// - a request is taken when start is high and busy is low: req_type picks
//   step, perturb, read or clear; cell_row, cell_col and perturb_amount go
//   with it
// - every request gives one result: result_valid is high for one cycle with
//   done_res high and cell_height holding the newest-grid height for a read,
//   zero otherwise; the receiver cannot hold results off
// - step: busy while it makes three newest-grid reads per cell on the two ram
//   read ports, result in the cycle after the last busy cycle
// - perturb and read each have a ram read state and then a write or output
//   state, out of range only the done state, result in the following cycle
// - clear sweeps both grids one cell a cycle, all GRID_SIZE^2 cells (4096)
// - after reset the same sweep runs with busy high and no result;
//   cfg_we writes damping or dead_zone at any time, meant only while idle
module water_ripple_grid_sim (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic [wrg_pkg::REQ_W-1:0]      req_type,
    input  wire logic [wrg_pkg::COORD_W-1:0]    cell_row,
    input  wire logic [wrg_pkg::COORD_W-1:0]    cell_col,
    input  wire logic signed [wrg_pkg::HEIGHT_W-1:0] perturb_amount,
    output logic                                result_valid,
    output logic signed [wrg_pkg::HEIGHT_W-1:0] cell_height,
    output logic                                done_res,
    input  wire logic                           cfg_we,
    input  wire logic [wrg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [wrg_pkg::CFG_W-1:0]      cfg_data
);

    localparam int GW = wrg_pkg::GRID_W;
    localparam int AW = wrg_pkg::ADDR_W;
    localparam int HW = wrg_pkg::HEIGHT_W;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_CLEAR  = 4'd1;
    localparam logic [3:0] S_ROW    = 4'd2;
    localparam logic [3:0] S_CA     = 4'd3;
    localparam logic [3:0] S_CB     = 4'd4;
    localparam logic [3:0] S_DRAIN1 = 4'd5;
    localparam logic [3:0] S_DRAIN2 = 4'd6;
    localparam logic [3:0] S_PRD    = 4'd7;
    localparam logic [3:0] S_PWR    = 4'd8;
    localparam logic [3:0] S_RRD    = 4'd9;
    localparam logic [3:0] S_ROUT   = 4'd10;
    localparam logic [3:0] S_DONE   = 4'd11;

    localparam logic [GW-1:0] LAST_INNER = GW'(wrg_pkg::GRID_SIZE - 2);

    logic [3:0]                   state_reg, state_next;
    logic [GW-1:0]                row_reg, row_next, col_reg, col_next;
    wrg_pkg::addr_t               sweep_reg, sweep_next;
    wrg_pkg::addr_t               req_addr_reg, req_addr_next;
    wrg_pkg::height_t             amount_reg, amount_next;
    logic                         newest_sel_reg, newest_sel_next;
    logic                         clear_report_reg, clear_report_next;
    logic                         result_valid_reg, result_valid_next;
    wrg_pkg::height_t             cell_height_reg, cell_height_next;
    logic [wrg_pkg::DAMP_W-1:0]   damping_reg;
    logic [wrg_pkg::DZ_W-1:0]     dead_zone_reg;

    wrg_pkg::addr_t     n_addr0, n_addr1, o_addr;
    logic               clr_we, pert_we;
    wrg_pkg::height_t   pert_data;
    wrg_pkg::upd_ctrl_t ctrl;
    wrg_pkg::grid_wr_t  step_wr;

    logic               older_we;
    wrg_pkg::addr_t     older_waddr, ram_waddr;
    wrg_pkg::height_t   older_wdata, ram_wdata;
    logic               a_we, b_we;
    wrg_pkg::addr_t     a_raddr0, b_raddr0;
    wrg_pkg::height_t   a_rd0, a_rd1, b_rd0, b_rd1;
    wrg_pkg::height_t   newest_rd0, newest_rd1, older_rd;

    logic               in_range;
    wrg_pkg::addr_t     req_idx;
    wrg_pkg::addr_t     r_a, r_up, r_dn, c_a, c_rt;
    logic signed [HW:0] pert_diff;

    assign in_range = (int'(cell_row) < wrg_pkg::GRID_SIZE)
                   && (int'(cell_col) < wrg_pkg::GRID_SIZE);
    assign req_idx = wrg_pkg::cell_addr(AW'(cell_row), AW'(cell_col));

    assign r_a  = AW'(row_reg);
    assign r_up = AW'(row_reg - GW'(1));
    assign r_dn = AW'(row_reg + GW'(1));
    assign c_a  = AW'(col_reg);
    assign c_rt = AW'(col_reg + GW'(1));

    assign pert_diff = $signed({older_rd[HW-1], older_rd})
                     - $signed({amount_reg[HW-1], amount_reg});

    always_comb
    begin
        state_next        = state_reg;
        row_next          = row_reg;
        col_next          = col_reg;
        sweep_next        = sweep_reg;
        req_addr_next     = req_addr_reg;
        amount_next       = amount_reg;
        newest_sel_next   = newest_sel_reg;
        clear_report_next = clear_report_reg;
        result_valid_next = 1'b0;
        cell_height_next  = '0;
        n_addr0           = '0;
        n_addr1           = '0;
        o_addr            = '0;
        clr_we            = 1'b0;
        pert_we           = 1'b0;
        pert_data         = '0;
        ctrl              = '0;

        if (pert_diff[HW] != pert_diff[HW-1])
        begin
            pert_data = pert_diff[HW] ? wrg_pkg::HEIGHT_NEG_MAX : wrg_pkg::HEIGHT_POS_MAX;
        end
        else
        begin
            pert_data = pert_diff[HW-1:0];
        end

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    req_addr_next = req_idx;
                    amount_next   = perturb_amount;
                    case (req_type)
                        wrg_pkg::REQ_STEP:
                        begin
                            row_next   = GW'(1);
                            col_next   = GW'(1);
                            state_next = S_ROW;
                        end
                        wrg_pkg::REQ_PERTURB:
                        begin
                            state_next = in_range ? S_PRD : S_DONE;
                        end
                        wrg_pkg::REQ_READ:
                        begin
                            state_next = in_range ? S_RRD : S_DONE;
                        end
                        wrg_pkg::REQ_CLEAR:
                        begin
                            sweep_next        = '0;
                            clear_report_next = 1'b1;
                            state_next        = S_CLEAR;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_CLEAR:
            begin
                clr_we = 1'b1;
                if (sweep_reg == AW'(wrg_pkg::CELL_COUNT - 1))
                begin
                    newest_sel_next   = 1'b0;
                    result_valid_next = clear_report_reg;
                    state_next        = S_IDLE;
                end
                else
                begin
                    sweep_next = sweep_reg + AW'(1);
                end
            end
            S_ROW:
            begin
                n_addr0    = wrg_pkg::cell_addr(r_a, '0);
                n_addr1    = wrg_pkg::cell_addr(r_a, AW'(1));
                state_next = S_CA;
            end
            S_CA:
            begin
                ctrl.load_row = (col_reg == GW'(1));
                n_addr0       = wrg_pkg::cell_addr(r_up, c_a);
                n_addr1       = wrg_pkg::cell_addr(r_dn, c_a);
                o_addr        = wrg_pkg::cell_addr(r_a, c_a);
                state_next    = S_CB;
            end
            S_CB:
            begin
                ctrl.load_vert = 1'b1;
                ctrl.addr      = wrg_pkg::cell_addr(r_a, c_a);
                n_addr0        = wrg_pkg::cell_addr(r_a, c_rt);
                if (col_reg != LAST_INNER)
                begin
                    col_next   = col_reg + GW'(1);
                    state_next = S_CA;
                end
                else if (row_reg != LAST_INNER)
                begin
                    row_next   = row_reg + GW'(1);
                    col_next   = GW'(1);
                    state_next = S_ROW;
                end
                else
                begin
                    state_next = S_DRAIN1;
                end
            end
            S_DRAIN1:
            begin
                state_next = S_DRAIN2;
            end
            S_DRAIN2:
            begin
                newest_sel_next   = ~newest_sel_reg;
                result_valid_next = 1'b1;
                state_next        = S_IDLE;
            end
            S_PRD:
            begin
                o_addr     = req_addr_reg;
                state_next = S_PWR;
            end
            S_PWR:
            begin
                pert_we           = 1'b1;
                result_valid_next = 1'b1;
                state_next        = S_IDLE;
            end
            S_RRD:
            begin
                n_addr0    = req_addr_reg;
                state_next = S_ROUT;
            end
            S_ROUT:
            begin
                cell_height_next  = newest_rd0;
                result_valid_next = 1'b1;
                state_next        = S_IDLE;
            end
            S_DONE:
            begin
                result_valid_next = 1'b1;
                state_next        = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_CLEAR;
            sweep_reg        <= '0;
            newest_sel_reg   <= 1'b0;
            clear_report_reg <= 1'b0;
            result_valid_reg <= 1'b0;
            damping_reg      <= wrg_pkg::DAMPING_RESET;
            dead_zone_reg    <= wrg_pkg::DEAD_ZONE_RESET;
        end
        else
        begin
            state_reg        <= state_next;
            sweep_reg        <= sweep_next;
            newest_sel_reg   <= newest_sel_next;
            clear_report_reg <= clear_report_next;
            result_valid_reg <= result_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    wrg_pkg::REG_DAMPING:   damping_reg   <= cfg_data[wrg_pkg::DAMP_W-1:0];
                    wrg_pkg::REG_DEAD_ZONE: dead_zone_reg <= cfg_data[wrg_pkg::DZ_W-1:0];
                    default:                ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        row_reg         <= row_next;
        col_reg         <= col_next;
        req_addr_reg    <= req_addr_next;
        amount_reg      <= amount_next;
        cell_height_reg <= cell_height_next;
    end

    // write port: clear sweep to both grids, otherwise step or perturb to older
    assign older_we    = step_wr.valid | pert_we;
    assign older_waddr = step_wr.valid ? step_wr.addr : req_addr_reg;
    assign older_wdata = step_wr.valid ? step_wr.data : pert_data;
    assign ram_waddr   = clr_we ? sweep_reg : older_waddr;
    assign ram_wdata   = clr_we ? '0 : older_wdata;
    assign a_we        = clr_we | (older_we & newest_sel_reg);
    assign b_we        = clr_we | (older_we & ~newest_sel_reg);

    // grid a is newest when newest_sel_reg is low
    assign a_raddr0   = newest_sel_reg ? o_addr : n_addr0;
    assign b_raddr0   = newest_sel_reg ? n_addr0 : o_addr;
    assign newest_rd0 = newest_sel_reg ? b_rd0 : a_rd0;
    assign newest_rd1 = newest_sel_reg ? b_rd1 : a_rd1;
    assign older_rd   = newest_sel_reg ? a_rd0 : b_rd0;

    wrg_ram #(
        .WIDTH (HW),
        .DEPTH (wrg_pkg::CELL_COUNT)
    ) u_grid_a (
        .clk    (clk),
        .we     (a_we),
        .waddr  (ram_waddr),
        .wdata  (ram_wdata),
        .raddr0 (a_raddr0),
        .raddr1 (n_addr1),
        .rdata0 (a_rd0),
        .rdata1 (a_rd1)
    );

    wrg_ram #(
        .WIDTH (HW),
        .DEPTH (wrg_pkg::CELL_COUNT)
    ) u_grid_b (
        .clk    (clk),
        .we     (b_we),
        .waddr  (ram_waddr),
        .wdata  (ram_wdata),
        .raddr0 (b_raddr0),
        .raddr1 (n_addr1),
        .rdata0 (b_rd0),
        .rdata1 (b_rd1)
    );

    wrg_update u_update (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .newest_rd0 (newest_rd0),
        .newest_rd1 (newest_rd1),
        .older_rd   (older_rd),
        .damping    (damping_reg),
        .dead_zone  (dead_zone_reg),
        .wr         (step_wr)
    );

    assign busy         = (state_reg != S_IDLE);
    assign result_valid = result_valid_reg;
    assign done_res     = result_valid_reg;
    assign cell_height  = cell_height_reg;

    a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(busy))
        else $error("result without a request in progress");

    a_accept_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not start");

    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !(a_we || b_we))
        else $error("grid written while idle");

    a_step_write_in_step: assert property (@(posedge clk) disable iff (!rst_n)
        step_wr.valid |-> (state_reg == S_CA || state_reg == S_CB
                           || state_reg == S_ROW || state_reg == S_DRAIN2))
        else $error("step write outside a step");

endmodule

`default_nettype wire
